// ===== hdl/mfom_pkg.sv =====
// ----------------------------------------------------------------------------
// mfom_pkg: shared definitions for the field-oriented mecanum mixer
// Widths, register codes and reset values, and the quarter-wave sine table,
// which is built once at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package mfom_pkg;

  // Sizing
  localparam int SINE_TABLE_DEPTH = 256;   // table steps over a quarter wave
  localparam int AXIS_BITS        = 16;    // stick and wheel word width

  localparam int DEADBAND_BITS = 15;
  localparam int GAIN_BITS     = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int TRIG_BITS     = 17;       // signed sine/cosine, +-32768
  localparam int LUT_BITS      = 16;       // unsigned table entry, 0..32768
  localparam int IDX_BITS      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int DB_CMP_BITS   = (AXIS_BITS > DEADBAND_BITS) ? AXIS_BITS : DEADBAND_BITS;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROTATION_GAIN  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_FRAME    = 2'd2;

  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = 15'd3277;
  localparam logic [GAIN_BITS-1:0]     GAIN_RESET     = 16'd16384;

  typedef logic signed [AXIS_BITS-1:0]  axis_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic [LUT_BITS-1:0]          sine_lut_t [0:SINE_TABLE_DEPTH];

  // Settings the mixer needs
  typedef struct packed {
    logic [GAIN_BITS-1:0] rotation_gain;
    logic                 field_frame;
  } mix_cfg_t;

  // Table construction (elaboration only)
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned LUT_DIVISOR = 64'(2 * SINE_TABLE_DEPTH);

  // sin(x) on [0, pi/2], Q30 in and out, Taylor series through x^13
  function automatic longint series_sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    return sum;
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t       lut;
    longint unsigned x;
    longint          s;
    longint          q;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (longint'(i) * PI_Q30 + 64'(SINE_TABLE_DEPTH)) / LUT_DIVISOR;
      s = series_sine_q30(x);
      if (s < 0) begin
        s = 0;
      end
      q = (s + 64'sd16384) >>> 15;
      if (q > 64'sd32768) begin
        q = 64'sd32768;
      end
      lut[i] = LUT_BITS'(q);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

// ===== hdl/mfom_deadzone.sv =====
// ----------------------------------------------------------------------------
// mfom_deadzone: stick deadband
// Force an axis to zero when its magnitude is below the deadband.
// ----------------------------------------------------------------------------
`default_nettype none

module mfom_deadzone (
  input  mfom_pkg::axis_t                        axis_i,
  input  logic [mfom_pkg::DEADBAND_BITS-1:0]     deadband_i,
  output mfom_pkg::axis_t                        axis_o
);

  logic [mfom_pkg::AXIS_BITS-1:0] mag;

  // Most negative value maps to 2^(n-1), which is correct as unsigned
  assign mag    = axis_i[mfom_pkg::AXIS_BITS-1] ? (~axis_i + 1'b1) : axis_i;
  assign axis_o = (mfom_pkg::DB_CMP_BITS'(mag) < mfom_pkg::DB_CMP_BITS'(deadband_i))
                  ? '0 : axis_i;

endmodule

`default_nettype wire

// ===== hdl/mfom_sine_lookup.sv =====
// ----------------------------------------------------------------------------
// mfom_sine_lookup: quarter-wave sine
// Binary angle in, signed Q1.15 sine out, nearest table entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mfom_sine_lookup (
  input  logic [mfom_pkg::ANGLE_BITS-1:0] angle_i,
  output mfom_pkg::trig_t                 sine_o
);

  localparam int ProdW = mfom_pkg::IDX_BITS + 14;

  logic [1:0]                      quad;
  logic [13:0]                     pos;
  logic [ProdW-1:0]                prod;
  logic [ProdW:0]                  prod_rnd;
  logic [mfom_pkg::IDX_BITS:0]     near;
  logic [mfom_pkg::IDX_BITS-1:0]   idx;
  logic [mfom_pkg::IDX_BITS-1:0]   sel;
  logic [mfom_pkg::LUT_BITS-1:0]   mag;
  mfom_pkg::trig_t                 mag_s;

  assign quad     = angle_i[15:14];
  assign pos      = angle_i[13:0];
  assign prod     = ProdW'(pos) * ProdW'(mfom_pkg::SINE_TABLE_DEPTH);
  assign prod_rnd = (ProdW + 1)'(prod) + (ProdW + 1)'(8192);
  assign near     = prod_rnd[ProdW:14];

  always_comb begin
    if (near > (mfom_pkg::IDX_BITS + 1)'(mfom_pkg::SINE_TABLE_DEPTH)) begin
      idx = mfom_pkg::IDX_BITS'(mfom_pkg::SINE_TABLE_DEPTH);
    end else begin
      idx = near[mfom_pkg::IDX_BITS-1:0];
    end
  end

  // Odd quadrants run the table backwards
  assign sel    = quad[0] ? (mfom_pkg::IDX_BITS'(mfom_pkg::SINE_TABLE_DEPTH) - idx) : idx;
  assign mag    = mfom_pkg::SINE_LUT[sel];
  assign mag_s  = $signed({1'b0, mag});
  assign sine_o = quad[1] ? -mag_s : mag_s;

endmodule

`default_nettype wire

// ===== hdl/mfom_mixer.sv =====
// ----------------------------------------------------------------------------
// mfom_mixer: turn scaling, field rotation and wheel mixing
// Scale the turn axis, rotate translation by heading, form and clamp speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module mfom_mixer (
  input  mfom_pkg::mix_cfg_t cfg_i,
  input  mfom_pkg::axis_t    fwd_i,
  input  mfom_pkg::axis_t    right_i,
  input  mfom_pkg::axis_t    turn_i,
  input  mfom_pkg::trig_t    sin_i,
  input  mfom_pkg::trig_t    cos_i,
  output mfom_pkg::axis_t    fl_o,
  output mfom_pkg::axis_t    fr_o,
  output mfom_pkg::axis_t    bl_o,
  output mfom_pkg::axis_t    br_o
);

  localparam int A    = mfom_pkg::AXIS_BITS;
  localparam int TW   = A + mfom_pkg::GAIN_BITS + 1;   // turn * gain
  localparam int PW   = A + mfom_pkg::TRIG_BITS;       // axis * trig
  localparam int SW   = PW + 1;                        // sum of two products
  localparam int RW   = A + 3;                         // rounded axis values
  localparam int WW   = A + 5;                         // wheel sums

  logic signed [TW-1:0] turn_prod, turn_rnd;
  logic signed [PW-1:0] fc, rs, rc, fs;
  logic signed [SW-1:0] nf_sum, nr_sum, nf_rnd, nr_rnd;
  logic signed [RW-1:0] turn_s, fwd_s, right_s;
  logic signed [WW-1:0] fl_w, fr_w, bl_w, br_w;

  // Turn: round(t * gain / 2^14), ties away from zero
  assign turn_prod = TW'(turn_i) * TW'($signed({1'b0, cfg_i.rotation_gain}));
  assign turn_rnd  = turn_prod + (turn_prod[TW-1] ? TW'(8191) : TW'(8192));
  assign turn_s    = RW'(turn_rnd[TW-1:14]);

  // Rotation by heading
  assign fc     = PW'(fwd_i) * PW'(cos_i);
  assign rs     = PW'(right_i) * PW'(sin_i);
  assign rc     = PW'(right_i) * PW'(cos_i);
  assign fs     = PW'(fwd_i) * PW'(sin_i);
  assign nf_sum = SW'(fc) + SW'(rs);
  assign nr_sum = SW'(rc) - SW'(fs);
  assign nf_rnd = nf_sum + (nf_sum[SW-1] ? SW'(16383) : SW'(16384));
  assign nr_rnd = nr_sum + (nr_sum[SW-1] ? SW'(16383) : SW'(16384));

  always_comb begin
    if (cfg_i.field_frame) begin
      fwd_s   = RW'(nf_rnd[SW-1:15]);
      right_s = RW'(nr_rnd[SW-1:15]);
    end else begin
      fwd_s   = RW'(fwd_i);
      right_s = RW'(right_i);
    end
  end

  assign fl_w = WW'(fwd_s) + WW'(turn_s) + WW'(right_s);
  assign fr_w = WW'(fwd_s) - WW'(turn_s) - WW'(right_s);
  assign bl_w = WW'(fwd_s) + WW'(turn_s) - WW'(right_s);
  assign br_w = WW'(fwd_s) - WW'(turn_s) + WW'(right_s);

  function automatic mfom_pkg::axis_t sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = WW'({1'b0, {(A-1){1'b1}}});
    lo = -hi - WW'(1);
    if (v > hi) begin
      return A'(hi);
    end else if (v < lo) begin
      return A'(lo);
    end
    return A'(v);
  endfunction

  assign fl_o = sat(fl_w);
  assign fr_o = sat(fr_w);
  assign bl_o = sat(bl_w);
  assign br_o = sat(br_w);

endmodule

`default_nettype wire

// ===== hdl/mecanum_field_oriented_mixer.sv =====
// ----------------------------------------------------------------------------
// mecanum_field_oriented_mixer: field-oriented mecanum wheel mixer
// Deadband, turn gain, heading rotation and four saturated wheel speeds.
// ----------------------------------------------------------------------------
// An item (three stick axes and a heading) is taken at every clock edge where
// start_i is high; busy_o never rises, so a new item may follow every cycle.
// Each item gives one set of four wheel speeds. The item is loaded into the
// input register; the result register, which drives done_o, is loaded after
// a single pass of deadband, multiply, rotate and mix logic.
// Results show for exactly one cycle and cannot be held off, so capture them
// when done_o is high. Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_field_oriented_mixer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [mfom_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [mfom_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // Item in
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  mfom_pkg::axis_t                      forward_axis_i,
  input  mfom_pkg::axis_t                      right_axis_i,
  input  mfom_pkg::axis_t                      turn_axis_i,
  input  logic signed [mfom_pkg::ANGLE_BITS-1:0] heading_i,
  // Result out
  output logic                                 done_o,
  output mfom_pkg::axis_t                      front_left_speed_o,
  output mfom_pkg::axis_t                      front_right_speed_o,
  output mfom_pkg::axis_t                      back_left_speed_o,
  output mfom_pkg::axis_t                      back_right_speed_o
);

  // Configuration registers
  logic [mfom_pkg::DEADBAND_BITS-1:0] deadband_q;
  logic [mfom_pkg::GAIN_BITS-1:0]     gain_q;
  logic                               field_q;

  // Input register
  logic                               in_valid_q;
  mfom_pkg::axis_t                    fwd_q, right_q, turn_q;
  logic [mfom_pkg::ANGLE_BITS-1:0]    heading_q;

  // Result register
  logic                               done_q;
  mfom_pkg::axis_t                    fl_q, fr_q, bl_q, br_q;

  // Datapath nets
  mfom_pkg::axis_t                    fwd_dz, right_dz, turn_dz;
  mfom_pkg::trig_t                    sin_v, cos_v;
  logic [mfom_pkg::ANGLE_BITS-1:0]    cos_angle;
  mfom_pkg::mix_cfg_t                 mix_cfg;
  mfom_pkg::axis_t                    fl_d, fr_d, bl_d, br_d;
  logic                               accept;

  // The pass has no busy state, so the input side never stalls
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= mfom_pkg::DEADBAND_RESET;
      gain_q     <= mfom_pkg::GAIN_RESET;
      field_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mfom_pkg::CFG_DEADBAND: begin
          deadband_q <= cfg_wdata_i[mfom_pkg::DEADBAND_BITS-1:0];
        end
        mfom_pkg::CFG_ROTATION_GAIN: begin
          gain_q <= cfg_wdata_i[mfom_pkg::GAIN_BITS-1:0];
        end
        mfom_pkg::CFG_FIELD_FRAME: begin
          field_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input stage: capture the item, mark it valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_q     <= forward_axis_i;
      right_q   <= right_axis_i;
      turn_q    <= turn_axis_i;
      heading_q <= heading_i;
    end
  end

  // Deadband on each axis
  mfom_deadzone u_dz_fwd (
    .axis_i     (fwd_q),
    .deadband_i (deadband_q),
    .axis_o     (fwd_dz)
  );

  mfom_deadzone u_dz_right (
    .axis_i     (right_q),
    .deadband_i (deadband_q),
    .axis_o     (right_dz)
  );

  mfom_deadzone u_dz_turn (
    .axis_i     (turn_q),
    .deadband_i (deadband_q),
    .axis_o     (turn_dz)
  );

  // Sine and cosine of heading; cosine is sine a quarter turn ahead
  assign cos_angle = heading_q + mfom_pkg::ANGLE_BITS'(16'h4000);

  mfom_sine_lookup u_sin (
    .angle_i (heading_q),
    .sine_o  (sin_v)
  );

  mfom_sine_lookup u_cos (
    .angle_i (cos_angle),
    .sine_o  (cos_v)
  );

  assign mix_cfg.rotation_gain = gain_q;
  assign mix_cfg.field_frame   = field_q;

  mfom_mixer u_mixer (
    .cfg_i   (mix_cfg),
    .fwd_i   (fwd_dz),
    .right_i (right_dz),
    .turn_i  (turn_dz),
    .sin_i   (sin_v),
    .cos_i   (cos_v),
    .fl_o    (fl_d),
    .fr_o    (fr_d),
    .bl_o    (bl_d),
    .br_o    (br_d)
  );

  // Result stage: strobe for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      fl_q <= fl_d;
      fr_q <= fr_d;
      bl_q <= bl_d;
      br_q <= br_d;
    end
  end

  assign done_o              = done_q;
  assign front_left_speed_o  = fl_q;
  assign front_right_speed_o = fr_q;
  assign back_left_speed_o   = bl_q;
  assign back_right_speed_o  = br_q;

`ifndef ASSERT_OFF
  // Every item in the input stage turns into exactly one result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(in_valid_q))
    else $error("result strobe does not follow input stage");

  // A still stick gives still wheels, whatever the heading and gain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && fwd_q == '0 && right_q == '0 && turn_q == '0) |=>
      (done_o && front_left_speed_o == '0 && front_right_speed_o == '0 &&
       back_left_speed_o == '0 && back_right_speed_o == '0))
    else $error("zero stick produced nonzero wheel speed");

  // Nothing reaches the result stage without a captured item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start_i) |=> !done_o)
    else $error("result strobe without an accepted item");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_mecanum_field_oriented_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_mecanum_field_oriented_mixer: self-checking bench for the wheel mixer
// Feeds stick items through a start/busy handshake and predicts every set of
// wheel speeds from an independent fixed-point model of the deadband, turn
// gain, heading rotation and saturation. Each done_o strobe is checked field
// by field against the oldest prediction. The run walks through several
// register settings and sender idle rates, then reports pass or fail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mecanum_field_oriented_mixer;

  localparam int LIMIT_CYCLES    = 200000;  // watchdog bound on the whole run
  localparam int DRAIN_CYCLES    = 8;       // covers the input and result registers plus margin
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES   = 8;
  localparam int PRESSURE_PHASE  = 4;

  // Index past the last register; the block must ignore writes to it
  localparam logic [mfom_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;

  localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;  // pi in Q30
  localparam longint WHEEL_MAX = (64'sd1 <<< (mfom_pkg::AXIS_BITS - 1)) - 1;
  localparam longint WHEEL_MIN = -WHEEL_MAX - 1;
  localparam mfom_pkg::axis_t AXIS_MAX = mfom_pkg::axis_t'(WHEEL_MAX);
  localparam mfom_pkg::axis_t AXIS_MIN = mfom_pkg::axis_t'(WHEEL_MIN);

  typedef struct {
    mfom_pkg::axis_t                         fwd;
    mfom_pkg::axis_t                         rgt;
    mfom_pkg::axis_t                         trn;
    logic signed [mfom_pkg::ANGLE_BITS-1:0]  hdg;
  } stick_item_t;

  typedef struct {
    mfom_pkg::axis_t fl;
    mfom_pkg::axis_t fr;
    mfom_pkg::axis_t bl;
    mfom_pkg::axis_t br;
  } wheel_set_t;

  // --------------------------------------------------------------------------
  // Block ports; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                                    clk_i          = 1'b0;
  logic                                    rst_ni         = 1'b0;
  logic                                    cfg_we_i       = 1'b0;
  logic [mfom_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i      = '0;
  logic [mfom_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i    = '0;
  logic                                    start_i        = 1'b0;
  logic                                    busy_o;
  mfom_pkg::axis_t                         forward_axis_i = '0;
  mfom_pkg::axis_t                         right_axis_i   = '0;
  mfom_pkg::axis_t                         turn_axis_i    = '0;
  logic signed [mfom_pkg::ANGLE_BITS-1:0]  heading_i      = '0;
  logic                                    done_o;
  mfom_pkg::axis_t                         front_left_speed_o;
  mfom_pkg::axis_t                         front_right_speed_o;
  mfom_pkg::axis_t                         back_left_speed_o;
  mfom_pkg::axis_t                         back_right_speed_o;

  mecanum_field_oriented_mixer u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .forward_axis_i      (forward_axis_i),
    .right_axis_i        (right_axis_i),
    .turn_axis_i         (turn_axis_i),
    .heading_i           (heading_i),
    .done_o              (done_o),
    .front_left_speed_o  (front_left_speed_o),
    .front_right_speed_o (front_right_speed_o),
    .back_left_speed_o   (back_left_speed_o),
    .back_right_speed_o  (back_right_speed_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Mixer model: register copies, sine table, and the wheel prediction
  // --------------------------------------------------------------------------
  logic [mfom_pkg::DEADBAND_BITS-1:0] deadband_m   = mfom_pkg::DEADBAND_BITS'(3277);
  logic [mfom_pkg::GAIN_BITS-1:0]     turn_gain_m  = mfom_pkg::GAIN_BITS'(16384);
  logic                               field_mode_m = 1'b0;
  longint                             sine_q15 [0:mfom_pkg::SINE_TABLE_DEPTH];

  stick_item_t  stick_pending_q[$];   // items waiting for the handshake
  wheel_set_t   wheel_expect_q[$];    // predicted speeds for items in flight
  int unsigned  sender_idle_pct = 0;
  int           mismatch_count  = 0;

  // sin(x) on a quarter wave, Q30 in and out, series through x^13
  function automatic longint taylor_sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    return acc;
  endfunction

  // Round to nearest, ties away from zero
  function automatic longint round_half_away(input longint v, input int sh);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r   = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Nearest-entry lookup: top two bits pick the quadrant, mirror on odd ones
  function automatic longint quarter_sine(input logic [mfom_pkg::ANGLE_BITS-1:0] ang);
    longint unsigned idx;
    longint          v;
    idx = (longint'(ang[13:0]) * mfom_pkg::SINE_TABLE_DEPTH + 8192) >> 14;
    if (idx > mfom_pkg::SINE_TABLE_DEPTH) begin
      idx = mfom_pkg::SINE_TABLE_DEPTH;
    end
    v = ang[14] ? sine_q15[mfom_pkg::SINE_TABLE_DEPTH - idx] : sine_q15[idx];
    return ang[15] ? -v : v;
  endfunction

  // Drop an axis to zero when its magnitude sits below the deadband
  function automatic longint apply_deadband(input mfom_pkg::axis_t a);
    longint v;
    longint mag;
    v   = longint'(a);
    mag = (v < 0) ? -v : v;
    return (mag < longint'(deadband_m)) ? 0 : v;
  endfunction

  function automatic mfom_pkg::axis_t clamp_wheel(input longint v);
    if (v > WHEEL_MAX) begin
      return AXIS_MAX;
    end
    if (v < WHEEL_MIN) begin
      return AXIS_MIN;
    end
    return mfom_pkg::axis_t'(v);
  endfunction

  function automatic wheel_set_t mix_wheels(input stick_item_t it);
    longint                            f;
    longint                            r;
    longint                            t;
    longint                            s;
    longint                            c;
    longint                            nf;
    logic [mfom_pkg::ANGLE_BITS-1:0]   cos_ang;
    wheel_set_t                        w;
    f = apply_deadband(it.fwd);
    r = apply_deadband(it.rgt);
    t = apply_deadband(it.trn);
    t = round_half_away(t * longint'(turn_gain_m), 14);
    if (field_mode_m) begin
      // Rotate translation into the field frame; cosine is sine a quarter on
      cos_ang = it.hdg + 16'h4000;
      s  = quarter_sine(it.hdg);
      c  = quarter_sine(cos_ang);
      nf = round_half_away(f * c + r * s, 15);
      r  = round_half_away(r * c - f * s, 15);
      f  = nf;
    end
    w.fl = clamp_wheel(f + t + r);
    w.fr = clamp_wheel(f - t - r);
    w.bl = clamp_wheel(f + t - r);
    w.br = clamp_wheel(f - t + r);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_item(input int f, input int r, input int t, input int h);
    stick_item_t it;
    it.fwd = mfom_pkg::axis_t'(f);
    it.rgt = mfom_pkg::axis_t'(r);
    it.trn = mfom_pkg::axis_t'(t);
    it.hdg = mfom_pkg::ANGLE_BITS'(h);
    stick_pending_q.push_back(it);
  endfunction

  // Random axis, weighted toward extremes and the deadband edge
  function automatic mfom_pkg::axis_t pick_axis();
    int sel;
    int mag;
    sel = int'($urandom_range(9));
    case (sel)
      0: return AXIS_MIN;
      1: return AXIS_MAX;
      2: return -AXIS_MAX;
      3: return '0;
      4, 5: begin
        mag = int'(deadband_m) + int'($urandom_range(6)) - 3;
        if (mag < 0) begin
          mag = 0;
        end
        if ($urandom_range(1) == 1) begin
          mag = -mag;
        end
        return mfom_pkg::axis_t'(mag);
      end
      6: return mfom_pkg::axis_t'(int'($urandom_range(4000)) - 2000);
      default: return mfom_pkg::axis_t'($urandom());
    endcase
  endfunction

  // Random heading, sometimes right at a quadrant boundary
  function automatic logic [mfom_pkg::ANGLE_BITS-1:0] pick_heading();
    logic [mfom_pkg::ANGLE_BITS-1:0] base;
    if ($urandom_range(7) == 0) begin
      base = mfom_pkg::ANGLE_BITS'($urandom_range(3)) << 14;
      return base + mfom_pkg::ANGLE_BITS'(int'($urandom_range(2)) - 1);
    end
    return mfom_pkg::ANGLE_BITS'($urandom());
  endfunction

  function automatic void push_random_item();
    stick_item_t it;
    it.fwd = pick_axis();
    it.rgt = pick_axis();
    it.trn = pick_axis();
    it.hdg = pick_heading();
    stick_pending_q.push_back(it);
  endfunction

  // Write one register and update the model copy; call only when idle
  task automatic write_reg(input logic [mfom_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [mfom_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      mfom_pkg::CFG_DEADBAND:      deadband_m   = data[mfom_pkg::DEADBAND_BITS-1:0];
      mfom_pkg::CFG_ROTATION_GAIN: turn_gain_m  = data[mfom_pkg::GAIN_BITS-1:0];
      mfom_pkg::CFG_FIELD_FRAME:   field_mode_m = data[0];
      default: ;  // unmapped index: the block must leave all registers alone
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_mixer(input int db, input int gain, input int field_mode);
    write_reg(mfom_pkg::CFG_DEADBAND, mfom_pkg::CFG_DATA_BITS'(db));
    write_reg(mfom_pkg::CFG_ROTATION_GAIN, mfom_pkg::CFG_DATA_BITS'(gain));
    write_reg(mfom_pkg::CFG_FIELD_FRAME, mfom_pkg::CFG_DATA_BITS'(field_mode));
  endtask

  // Hold until every item is taken and every wheel set has come back
  task automatic wait_drained();
    while (stick_pending_q.size() != 0 || wheel_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the oldest pending item, advance on start && !busy
  // --------------------------------------------------------------------------
  // The handshake is judged on the values that stood before this edge; the
  // next value of start_i is worked out first and assigned once.
  always @(posedge clk_i) begin : item_driver
    logic go;
    go = start_i;
    if (start_i && !busy_o) begin
      wheel_expect_q.push_back(mix_wheels(stick_pending_q.pop_front()));
      go = 1'b0;
    end
    if (!go && stick_pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      go = 1'b1;
    end
    start_i <= go;
    if (go) begin
      forward_axis_i <= stick_pending_q[0].fwd;
      right_axis_i   <= stick_pending_q[0].rgt;
      turn_axis_i    <= stick_pending_q[0].trn;
      heading_i      <= stick_pending_q[0].hdg;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done_o strobe must match the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_wheel(input string name, input mfom_pkg::axis_t want,
                                      input mfom_pkg::axis_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : wheel_monitor
    wheel_set_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (wheel_expect_q.size() == 0) begin
        $display("%0t: unexpected wheel set, expected none actual %0d %0d %0d %0d",
                 $time, front_left_speed_o, front_right_speed_o,
                 back_left_speed_o, back_right_speed_o);
        mismatch_count++;
      end else begin
        want = wheel_expect_q.pop_front();
        check_wheel("front_left_speed", want.fl, front_left_speed_o);
        check_wheel("front_right_speed", want.fr, front_right_speed_o);
        check_wheel("back_left_speed", want.bl, back_left_speed_o);
        check_wheel("back_right_speed", want.br, back_right_speed_o);
      end
    end
  end

  // Watchdog: drop the run if it hangs
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("mecanum_field_oriented_mixer verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  int unsigned idle_rates [3] = '{0, 58, 38};

  initial begin : test_sequence
    longint unsigned x;
    longint          s;
    longint          q;

    // Build the quarter-wave table: entry i is sin(i/DEPTH * 90 deg) in Q15
    for (longint unsigned i = 0; i <= mfom_pkg::SINE_TABLE_DEPTH; i++) begin
      x = (i * HALF_TURN_Q30 + mfom_pkg::SINE_TABLE_DEPTH) /
          (2 * mfom_pkg::SINE_TABLE_DEPTH);
      s = taylor_sine_q30(x);
      if (s < 0) begin
        s = 0;
      end
      q = (s + 16384) >>> 15;
      if (q > 32768) begin
        q = 32768;
      end
      sine_q15[i] = q;
    end

    // Hold reset, then release it on a clock edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed, reset settings (robot frame): extremes and the deadband edge
    sender_idle_pct = 0;
    push_item(0, 0, 0, 0);
    push_item(32767, 0, 0, 0);
    push_item(-32768, 0, 0, 0);
    push_item(0, 32767, 0, 0);
    push_item(0, -32768, 0, 0);
    push_item(0, 0, 32767, 0);
    push_item(0, 0, -32768, 0);
    push_item(3276, -3276, 3277, 0);       // just under and right at the deadband
    push_item(-3277, 3277, -3276, 0);
    push_item(32767, 32767, 32767, 16'h7FFF);  // heading must not matter here
    push_item(-32768, -32768, -32768, -32768);
    push_item(12000, -9000, 5000, 16'h2000);
    wait_drained();

    // Directed, no deadband, full gain, field frame; unmapped write ignored
    set_mixer(0, 16'hFFFF, 1);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    push_item(1, -1, 1, 0);
    push_item(32767, 0, 0, 16'h4000);
    push_item(32767, 0, 0, 16'h8000);
    push_item(32767, 0, 0, 16'hC000);
    push_item(0, 32767, 0, 16'h2000);
    push_item(-32768, -32768, -32768, 16'h7FFF);
    push_item(20000, 10000, -32768, 16'hFFFF);
    push_item(32767, 32767, 32767, 16'h6000);
    push_item(0, 0, 32767, 0);
    push_item(16384, -16384, 0, 16'h1234);

    // Random phases, each under its own settings and sender idle rate
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: set_mixer(0, 0, 1);                  // no deadband, turn gain off
        1: set_mixer(16'h7FFF, 16'hFFFF, 0);    // widest deadband, top gain
        2: set_mixer(16'hFFFF, 16'hFFFF, 1);    // top bit of deadband data dropped
        3: set_mixer(3277, 16384, 1);
        default: begin
          if (p % 2 == 0) begin
            set_mixer(int'($urandom_range(6000)), int'($urandom_range(65535)),
                      int'($urandom_range(1)));
          end else begin
            set_mixer(int'($urandom_range(65535)), int'($urandom_range(65535)),
                      int'($urandom_range(1)));
          end
        end
      endcase
      sender_idle_pct = idle_rates[p % 3];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Let the pipe run dry once in the middle of a phase
        if (p == PRESSURE_PHASE && n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        push_random_item();
      end
    end

    wait_drained();
    if (mismatch_count == 0 && wheel_expect_q.size() == 0) begin
      $display("mecanum_field_oriented_mixer verification clean");
    end else begin
      $display("mecanum_field_oriented_mixer verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mfom_pkg.sv
hdl/mfom_deadzone.sv
hdl/mfom_sine_lookup.sv
hdl/mfom_mixer.sv
hdl/mecanum_field_oriented_mixer.sv
sim/tb_mecanum_field_oriented_mixer.sv
